// ===== src/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned TAKE_W = 2;
  localparam int unsigned SEL_W  = 3;

  // Replacement character for bad input
  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Allowed range codes for the second byte of a sequence
  localparam logic [SEL_W-1:0] RNG_80_BF = 3'd0;
  localparam logic [SEL_W-1:0] RNG_A0_BF = 3'd1;
  localparam logic [SEL_W-1:0] RNG_80_9F = 3'd2;
  localparam logic [SEL_W-1:0] RNG_90_BF = 3'd3;
  localparam logic [SEL_W-1:0] RNG_80_8F = 3'd4;

  // Job queue between the classifier and the result generator
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One job: a run of buffered errors, then optionally one final result
  typedef struct packed {
    logic [TAKE_W-1:0] err_cnt;
    logic              has_tail;
    logic [CP_W-1:0]   tail_cp;
    logic [LEN_W-1:0]  tail_len;
    logic              tail_bad;
  } job_t;

endpackage

// ===== src/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with replacement on bad input.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the four-entry job queue has room.
// The classifier turns each byte that yields results into a job at once;
// the result generator then sends one result per cycle while the output
// is not stalled; a byte yields up to four (a failed four-byte sequence).
// Jobs are registered in the queue, results in the output register. Sustained
// rate is one byte per cycle for streams that give about one result per byte;
// error bursts and output stalls fill the queue and then stall the input.
module utf8_stream_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [u8d_pkg::BYTE_W-1:0]    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u8d_pkg::CP_W-1:0]      code_point_o,
  output logic [u8d_pkg::LEN_W-1:0]     seq_bytes_o,
  output logic                          is_invalid_o,
  output logic                          run_end_o
);

  logic          push, pop, full, nempty;
  u8d_pkg::job_t job, head;

  assign in_stall_o = full;

  // Classifier
  u8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (full),
    .in_byte_i  (in_byte_i),
    .push_o     (push),
    .job_o      (job)
  );

  // Job queue
  u8d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .full_o   (full),
    .nempty_o (nempty),
    .head_o   (head)
  );

  // Result generator
  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (nempty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .seq_bytes_o  (seq_bytes_o),
    .is_invalid_o (is_invalid_o),
    .run_end_o    (run_end_o)
  );

endmodule

// ===== src/u8d_front.sv =====
// ----------------------------------------------------------------------------
// u8d_front
// Byte classifier: tracks the open sequence; a byte with results makes a job.
// ----------------------------------------------------------------------------
module u8d_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [u8d_pkg::BYTE_W-1:0]      in_byte_i,
  output logic                            push_o,
  output u8d_pkg::job_t                   job_o
);

  // Sequence state
  logic [u8d_pkg::LEN_W-1:0]  exp_len_q, exp_len_d;
  logic [u8d_pkg::TAKE_W-1:0] taken_q, taken_d;
  logic [u8d_pkg::CP_W-1:0]   acc_q, acc_d;
  logic [u8d_pkg::SEL_W-1:0]  sel_q, sel_d;

  logic [u8d_pkg::BYTE_W-1:0] b;
  logic [u8d_pkg::SEL_W-1:0]  rng_sel;
  logic [u8d_pkg::BYTE_W-1:0] lo, hi;
  logic                       in_rng;
  logic [u8d_pkg::CP_W-1:0]   acc_new;
  logic [u8d_pkg::LEN_W-1:0]  taken_inc;
  logic                       redo;
  logic                       accept;
  u8d_pkg::job_t              job;

  assign b      = in_byte_i;
  assign accept = in_valid_i && !in_stall_i;

  // Range check for a continuation byte; narrowed only on the second byte
  always_comb begin
    rng_sel = (taken_q == 2'd1) ? sel_q : u8d_pkg::RNG_80_BF;
    lo = 8'h80;
    hi = 8'hBF;
    case (rng_sel)
      u8d_pkg::RNG_A0_BF: lo = 8'hA0;
      u8d_pkg::RNG_80_9F: hi = 8'h9F;
      u8d_pkg::RNG_90_BF: lo = 8'h90;
      u8d_pkg::RNG_80_8F: hi = 8'h8F;
      default: ;
    endcase
    in_rng = (b >= lo) && (b <= hi);
  end

  assign acc_new   = {acc_q[u8d_pkg::CP_W-7:0], b[5:0]};
  assign taken_inc = {1'b0, taken_q} + 3'd1;

  // Classification and next sequence state
  always_comb begin
    exp_len_d = exp_len_q;
    taken_d   = taken_q;
    acc_d     = acc_q;
    sel_d     = sel_q;
    job       = '0;
    redo      = 1'b1;

    if (exp_len_q != '0) begin
      if (b == 8'h00) begin
        // end of string: flush buffered bytes as errors
        job.err_cnt = taken_q;
        exp_len_d = '0; taken_d = '0; acc_d = '0; sel_d = u8d_pkg::RNG_80_BF;
        redo = 1'b0;
      end else if (in_rng) begin
        acc_d = acc_new;
        if (taken_inc >= exp_len_q) begin
          job.has_tail = 1'b1;
          job.tail_cp  = acc_new;
          job.tail_len = exp_len_q;
          job.tail_bad = 1'b0;
          exp_len_d = '0; taken_d = '0; acc_d = '0; sel_d = u8d_pkg::RNG_80_BF;
        end else begin
          taken_d = taken_inc[u8d_pkg::TAKE_W-1:0];
        end
        redo = 1'b0;
      end else begin
        // bad continuation: flush, then treat the byte as a lead
        job.err_cnt = taken_q;
        exp_len_d = '0; taken_d = '0; acc_d = '0; sel_d = u8d_pkg::RNG_80_BF;
      end
    end

    if (redo && (b != 8'h00)) begin
      if (b < 8'h80) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {13'd0, b};
        job.tail_len = 3'd1;
        job.tail_bad = 1'b0;
      end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
        exp_len_d = 3'd2; taken_d = 2'd1;
        acc_d = {16'd0, b[4:0]};
        sel_d = u8d_pkg::RNG_80_BF;
      end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
        exp_len_d = 3'd3; taken_d = 2'd1;
        acc_d = {17'd0, b[3:0]};
        sel_d = (b == 8'hE0) ? u8d_pkg::RNG_A0_BF :
                (b == 8'hED) ? u8d_pkg::RNG_80_9F : u8d_pkg::RNG_80_BF;
      end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
        exp_len_d = 3'd4; taken_d = 2'd1;
        acc_d = {18'd0, b[2:0]};
        sel_d = (b == 8'hF0) ? u8d_pkg::RNG_90_BF :
                (b == 8'hF4) ? u8d_pkg::RNG_80_8F : u8d_pkg::RNG_80_BF;
      end else begin
        // invalid lead byte
        job.has_tail = 1'b1;
        job.tail_cp  = u8d_pkg::REPL_CP;
        job.tail_len = 3'd1;
        job.tail_bad = 1'b1;
      end
    end
  end

  assign push_o = accept && ((job.err_cnt != '0) || job.has_tail);
  assign job_o  = job;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      taken_q   <= '0;
      acc_q     <= '0;
      sel_q     <= u8d_pkg::RNG_80_BF;
    end else if (accept) begin
      exp_len_q <= exp_len_d;
      taken_q   <= taken_d;
      acc_q     <= acc_d;
      sel_q     <= sel_d;
    end
  end

endmodule

// ===== src/u8d_queue.sv =====
// ----------------------------------------------------------------------------
// u8d_queue
// Small job FIFO between the classifier and the result generator.
// ----------------------------------------------------------------------------
module u8d_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u8d_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          nempty_o,
  output u8d_pkg::job_t head_o
);

  u8d_pkg::job_t                 mem_q [u8d_pkg::Q_DEPTH];
  logic [u8d_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [u8d_pkg::Q_CNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o   = (cnt_q == u8d_pkg::Q_CNT_W'(u8d_pkg::Q_DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign head_o   = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + u8d_pkg::Q_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + u8d_pkg::Q_PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + u8d_pkg::Q_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - u8d_pkg::Q_CNT_W'(1);
    end
  end

endmodule

// ===== src/u8d_back.sv =====
// ----------------------------------------------------------------------------
// u8d_back
// Result generator: expands jobs into results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module u8d_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  u8d_pkg::job_t                 head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u8d_pkg::CP_W-1:0]      code_point_o,
  output logic [u8d_pkg::LEN_W-1:0]     seq_bytes_o,
  output logic                          is_invalid_o,
  output logic                          run_end_o
);

  logic [u8d_pkg::TAKE_W-1:0] done_q;
  logic [u8d_pkg::TAKE_W-1:0] err_left;
  logic                       emit_err, last, load;

  logic                       out_valid_q;
  logic [u8d_pkg::CP_W-1:0]   cp_q;
  logic [u8d_pkg::LEN_W-1:0]  len_q;
  logic                       bad_q, end_q;

  // Pick the next result of the head job
  assign err_left = head_i.err_cnt - done_q;
  assign emit_err = (err_left != '0);
  assign last     = emit_err ? ((err_left == 2'd1) && !head_i.has_tail) : 1'b1;
  assign load     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && last;

  // Errors emitted so far for the head job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (load) begin
      done_q <= last ? '0 : done_q + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q  <= emit_err ? u8d_pkg::REPL_CP : head_i.tail_cp;
      len_q <= emit_err ? 3'd1 : head_i.tail_len;
      bad_q <= emit_err ? 1'b1 : head_i.tail_bad;
      end_q <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign seq_bytes_o  = len_q;
  assign is_invalid_o = bad_q;
  assign run_end_o    = end_q;

endmodule

// ===== src/u8d_checker.sv =====
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module u8d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [u8d_pkg::CP_W-1:0]      code_point_o,
  input logic [u8d_pkg::LEN_W-1:0]     seq_bytes_o,
  input logic                          is_invalid_o,
  input logic                          run_end_o
);

  // Stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o)
      && $stable(seq_bytes_o) && $stable(is_invalid_o) && $stable(run_end_o))
    else $error("stalled result changed");

  // Replacements are always U+FFFD of length one
  a_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_invalid_o |-> (code_point_o == u8d_pkg::REPL_CP)
      && (seq_bytes_o == 3'd1))
    else $error("bad replacement result");

  // Decoded values are scalar values with a sane length
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_invalid_o |-> (code_point_o <= 21'h10FFFF)
      && !((code_point_o >= 21'h00D800) && (code_point_o <= 21'h00DFFF))
      && (seq_bytes_o >= 3'd1) && (seq_bytes_o <= 3'd4))
    else $error("decoded value out of range");

  // Single-byte results are ASCII and close their run
  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_invalid_o && (seq_bytes_o == 3'd1)
      |-> (code_point_o < 21'h000080) && run_end_o)
    else $error("single-byte result not ASCII");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (.*);
